### rtl/jtm_pkg.sv
// ---------------------------------------------------------------------------
// jtm_pkg
// Shared types and constants of the two-machine flow-shop scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package jtm_pkg;

	localparam int KINDS      = 4;
	localparam int KIND_W     = 2;
	localparam int TIME_W     = 8;
	localparam int FIN_W      = 13;
	localparam int IDX_W      = 4;
	localparam int KEY_W      = TIME_W + 1;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 32;
	localparam logic [FIN_W-1:0] FIN_MAX = {FIN_W{1'b1}};

	// register indexes
	localparam logic [2:0] REG_M1_KIND0 = 3'd0;
	localparam logic [2:0] REG_M2_KIND0 = 3'd4;

	typedef logic [KINDS-1:0][TIME_W-1:0] time_tab_t;

	// scheduler sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_RD,
		ST_CHK,
		ST_ACC1,
		ST_ACC2
	} jtm_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_en;
		logic pick_en;
		logic addr_clr;
		logic addr_inc;
		logic acc1_en;
		logic out_load;
		logic sched_end;
	} jtm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;
		logic hit;
		logic out_free;
		logic is_last;
	} jtm_status_t;

	// johnson sort key: front group ascending t1, back group descending t2
	function automatic logic [KEY_W-1:0] sort_key(input logic [TIME_W-1:0] t1,
			input logic [TIME_W-1:0] t2);
		logic front;
		front = (t1 <= t2);
		sort_key = front ? {1'b0, t1} : {1'b1, ~t2};
	endfunction

	// saturating finish time add
	function automatic logic [FIN_W-1:0] sat_add(input logic [FIN_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [FIN_W:0] s;
		s = {1'b0, a} + {{(FIN_W+1-TIME_W){1'b0}}, b};
		sat_add = s[FIN_W] ? FIN_MAX : s[FIN_W-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/jtm_cfg_regs.sv
// ---------------------------------------------------------------------------
// jtm_cfg_regs
// APB register file holding the machine one and machine two times per kind.
// ---------------------------------------------------------------------------
`default_nettype none

module jtm_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [jtm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [jtm_pkg::PDATA_W-1:0]  pwdata,
	output logic      [jtm_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	output jtm_pkg::time_tab_t                t1_tab,
	output jtm_pkg::time_tab_t                t2_tab
);

	jtm_pkg::time_tab_t t1_q;
	jtm_pkg::time_tab_t t2_q;
	logic [2:0]         reg_idx;
	logic [1:0]         kind_sel;
	logic               wr_en;

	assign reg_idx  = paddr[4:2];
	assign kind_sel = reg_idx[1:0];
	assign wr_en    = psel && penable && pwrite;
	assign pready   = 1'b1;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q <= '0;
			t2_q <= '0;
		end else if (wr_en) begin
			if (reg_idx < jtm_pkg::REG_M2_KIND0) begin
				t1_q[kind_sel] <= pwdata[jtm_pkg::TIME_W-1:0];
			end else begin
				t2_q[kind_sel] <= pwdata[jtm_pkg::TIME_W-1:0];
			end
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (reg_idx < jtm_pkg::REG_M2_KIND0) begin
			prdata[jtm_pkg::TIME_W-1:0] = t1_q[kind_sel];
		end else begin
			prdata[jtm_pkg::TIME_W-1:0] = t2_q[kind_sel];
		end
	end

	assign t1_tab = t1_q;
	assign t2_tab = t2_q;

endmodule

`default_nettype wire

### rtl/jtm_datapath.sv
// ---------------------------------------------------------------------------
// jtm_datapath
// Job memory, kind class selection, finish time accumulators, output register.
// ---------------------------------------------------------------------------
`default_nettype none

module jtm_datapath #(
	parameter int JOBS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire jtm_pkg::jtm_cmd_t             cmd,
	output jtm_pkg::jtm_status_t               status,
	input  wire jtm_pkg::time_tab_t            t1_tab,
	input  wire jtm_pkg::time_tab_t            t2_tab,
	input  wire logic [jtm_pkg::KIND_W-1:0]    job_kind,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [jtm_pkg::IDX_W-1:0]     job_index,
	output logic      [jtm_pkg::KIND_W-1:0]    job_kind_out,
	output logic      [jtm_pkg::FIN_W-1:0]     m1_finish,
	output logic      [jtm_pkg::FIN_W-1:0]     m2_finish,
	output logic                               sched_last
);

	localparam int AW = (JOBS > 1) ? $clog2(JOBS) : 1;
	localparam int CW = $clog2(JOBS + 1);

	logic [jtm_pkg::KIND_W-1:0] job_mem [JOBS];

	logic [CW-1:0]               count_q;
	logic [CW-1:0]               emit_q;
	logic [AW-1:0]               addr_q;
	logic [jtm_pkg::KIND_W-1:0]  rdata_q;
	logic [jtm_pkg::KINDS-1:0]   present_q;
	logic [jtm_pkg::KINDS-1:0]   done_q;
	logic [jtm_pkg::KINDS-1:0]   class_q;
	logic [jtm_pkg::FIN_W-1:0]   c1_q;
	logic [jtm_pkg::FIN_W-1:0]   c2_q;
	logic                        out_valid_q;

	logic                        full;
	logic [jtm_pkg::KINDS-1:0]   avail;
	logic [jtm_pkg::KINDS-1:0]   class_nx;
	logic [jtm_pkg::KEY_W-1:0]   key   [jtm_pkg::KINDS];
	logic [jtm_pkg::KEY_W-1:0]   min_key;
	logic                        min_found;
	logic [jtm_pkg::FIN_W-1:0]   c_max;
	logic [jtm_pkg::FIN_W-1:0]   c2_nx;
	logic [AW+jtm_pkg::IDX_W-1:0] idx_ext;

	assign full = (count_q == CW'(JOBS));

	// job memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.load_en && !full) begin
			job_mem[count_q[AW-1:0]] <= job_kind;
		end
		rdata_q <= job_mem[addr_q];
	end

	// fill count and kinds present in the set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			present_q <= '0;
		end else if (cmd.sched_end) begin
			count_q   <= '0;
			present_q <= '0;
		end else if (cmd.load_en && !full) begin
			count_q            <= count_q + CW'(1);
			present_q[job_kind] <= 1'b1;
		end
	end

	// smallest sort key among kinds not yet scheduled
	always_comb begin
		min_key   = '1;
		min_found = 1'b0;
		for (int k = 0; k < jtm_pkg::KINDS; k++) begin
			key[k] = jtm_pkg::sort_key(t1_tab[k], t2_tab[k]);
		end
		avail = present_q & ~done_q;
		for (int k = 0; k < jtm_pkg::KINDS; k++) begin
			if (avail[k] && (!min_found || key[k] < min_key)) begin
				min_key   = key[k];
				min_found = 1'b1;
			end
		end
		for (int k = 0; k < jtm_pkg::KINDS; k++) begin
			class_nx[k] = avail[k] && (key[k] == min_key);
		end
	end

	// current key class and scanned kinds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= '0;
			done_q  <= '0;
		end else if (cmd.sched_end) begin
			done_q <= '0;
		end else if (cmd.pick_en) begin
			class_q <= class_nx;
			done_q  <= done_q | class_nx;
		end
	end

	// scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.addr_clr) begin
			addr_q <= '0;
		end else if (cmd.addr_inc) begin
			addr_q <= addr_q + AW'(1);
		end
	end

	// finish time accumulators
	assign c_max = (c1_q > c2_q) ? c1_q : c2_q;
	assign c2_nx = jtm_pkg::sat_add(c_max, t2_tab[rdata_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q   <= '0;
			c2_q   <= '0;
			emit_q <= '0;
		end else if (cmd.sched_end) begin
			c1_q   <= '0;
			c2_q   <= '0;
			emit_q <= '0;
		end else begin
			if (cmd.acc1_en) begin
				c1_q <= jtm_pkg::sat_add(c1_q, t1_tab[rdata_q]);
			end
			if (cmd.out_load) begin
				c2_q   <= c2_nx;
				emit_q <= emit_q + CW'(1);
			end
		end
	end

	// output register
	assign idx_ext = (AW + jtm_pkg::IDX_W)'(addr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			job_index    <= idx_ext[jtm_pkg::IDX_W-1:0];
			job_kind_out <= rdata_q;
			m1_finish    <= c1_q;
			m2_finish    <= c2_nx;
			sched_last   <= status.is_last;
		end
	end

	assign out_valid = out_valid_q;

	// status to the controller
	assign status.scan_end = ((CW'(addr_q) + CW'(1)) == count_q);
	assign status.hit      = class_q[rdata_q];
	assign status.out_free = !out_valid_q || !out_stall;
	assign status.is_last  = ((emit_q + CW'(1)) == count_q);

endmodule

`default_nettype wire

### rtl/jtm_ctrl.sv
// ---------------------------------------------------------------------------
// jtm_ctrl
// Sequencer for loading, class selection, memory scan and result emission.
// ---------------------------------------------------------------------------
`default_nettype none

module jtm_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  load_last,
	input  wire jtm_pkg::jtm_status_t  status,
	output jtm_pkg::jtm_cmd_t          cmd
);

	jtm_pkg::jtm_state_t state_q;
	jtm_pkg::jtm_state_t state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jtm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			jtm_pkg::ST_IDLE: begin
				if (in_valid && load_last) begin
					state_nx = jtm_pkg::ST_PICK;
				end
			end
			jtm_pkg::ST_PICK: state_nx = jtm_pkg::ST_RD;
			jtm_pkg::ST_RD:   state_nx = jtm_pkg::ST_CHK;
			jtm_pkg::ST_CHK: begin
				if (status.hit) begin
					state_nx = jtm_pkg::ST_ACC1;
				end else if (status.scan_end) begin
					state_nx = jtm_pkg::ST_PICK;
				end else begin
					state_nx = jtm_pkg::ST_RD;
				end
			end
			jtm_pkg::ST_ACC1: state_nx = jtm_pkg::ST_ACC2;
			jtm_pkg::ST_ACC2: begin
				if (status.out_free) begin
					if (status.is_last) begin
						state_nx = jtm_pkg::ST_IDLE;
					end else if (status.scan_end) begin
						state_nx = jtm_pkg::ST_PICK;
					end else begin
						state_nx = jtm_pkg::ST_RD;
					end
				end
			end
			default: state_nx = jtm_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			jtm_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_en = in_valid;
			end
			jtm_pkg::ST_PICK: begin
				cmd.pick_en  = 1'b1;
				cmd.addr_clr = 1'b1;
			end
			jtm_pkg::ST_RD: begin
			end
			jtm_pkg::ST_CHK: begin
				cmd.addr_inc = !status.hit && !status.scan_end;
			end
			jtm_pkg::ST_ACC1: begin
				cmd.acc1_en = 1'b1;
			end
			jtm_pkg::ST_ACC2: begin
				cmd.out_load  = status.out_free;
				cmd.sched_end = status.out_free && status.is_last;
				cmd.addr_inc  = status.out_free && !status.is_last && !status.scan_end;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/johnson_two_machine_scheduler_unit.sv
// ---------------------------------------------------------------------------
// johnson_two_machine_scheduler_unit
// Two-machine flow-shop scheduler ordering a loaded job set by Johnson's rule.
// ---------------------------------------------------------------------------
// Usage: program the machine one and machine two times of the four job kinds
// over the APB port (byte address 4*i, registers 0..3 machine one, 4..7
// machine two), then load jobs one transaction each on the input channel.
// Jobs beyond JOBS are dropped. The transaction with load_last set starts
// scheduling; the input stalls until the last result has entered the output
// register. One output transaction per job follows in schedule order with its
// finish times; sched_last marks the final one, whose m2_finish is the makespan.
// Loading accepts one job per cycle while idle. Scheduling scans the job memory
// once per distinct sort key class (at most four), reading each entry through
// the registered memory read in states RD and CHK, and passes each emitted job
// through states ACC1 and ACC2. A stalled receiver holds the output register
// and the scan waits for it. Reset clears the job count, the times and the
// output valid; the job memory needs no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module johnson_two_machine_scheduler_unit #(
	parameter int JOBS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [jtm_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [jtm_pkg::PDATA_W-1:0]   pwdata,
	output logic      [jtm_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	// job input
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [jtm_pkg::KIND_W-1:0]    job_kind,
	input  wire logic                          load_last,
	// schedule output
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [jtm_pkg::IDX_W-1:0]     job_index,
	output logic      [jtm_pkg::KIND_W-1:0]    job_kind_out,
	output logic      [jtm_pkg::FIN_W-1:0]     m1_finish,
	output logic      [jtm_pkg::FIN_W-1:0]     m2_finish,
	output logic                               sched_last
);

	jtm_pkg::time_tab_t   t1_tab;
	jtm_pkg::time_tab_t   t2_tab;
	jtm_pkg::jtm_cmd_t    cmd;
	jtm_pkg::jtm_status_t status;

	// time registers
	jtm_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.t1_tab  (t1_tab),
		.t2_tab  (t2_tab)
	);

	// sequencer
	jtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.load_last (load_last),
		.status    (status),
		.cmd       (cmd)
	);

	// job memory and finish time datapath
	jtm_datapath #(
		.JOBS (JOBS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.t1_tab       (t1_tab),
		.t2_tab       (t2_tab),
		.job_kind     (job_kind),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.job_index    (job_index),
		.job_kind_out (job_kind_out),
		.m1_finish    (m1_finish),
		.m2_finish    (m2_finish),
		.sched_last   (sched_last)
	);

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the Johnson's rule two-machine scheduler: loads job
// sets on the input channel, programs kind times over APB between sets and
// checks every transaction against an in-bench Johnson model or typed row.
// ---------------------------------------------------------------------------

module tb;

	localparam int JOBS  = 16;
	localparam int ITEMS = 310;

	// time presets selected by the directed table
	localparam logic [1:0] CFG_KEEP       = 2'd0;
	localparam logic [1:0] CFG_FULL_SCALE = 2'd1;
	localparam logic [1:0] CFG_MIXED      = 2'd2;
	localparam logic [1:0] CFG_TIES       = 2'd3;

	// per preset, kind 3 first
	localparam jtm_pkg::time_tab_t PRESET_M1 [4] = '{
		{8'd0, 8'd0, 8'd0, 8'd0},
		{8'd255, 8'd255, 8'd255, 8'd255},
		{8'd255, 8'd200, 8'd10, 8'd0},
		{8'd200, 8'd9, 8'd9, 8'd5}
	};
	localparam jtm_pkg::time_tab_t PRESET_M2 [4] = '{
		{8'd0, 8'd0, 8'd0, 8'd0},
		{8'd255, 8'd255, 8'd255, 8'd255},
		{8'd0, 8'd100, 8'd20, 8'd0},
		{8'd200, 8'd3, 8'd3, 8'd7}
	};

	typedef struct packed {
		logic [jtm_pkg::IDX_W-1:0]  idx;
		logic [jtm_pkg::KIND_W-1:0] kind;
		logic [jtm_pkg::FIN_W-1:0]  m1;
		logic [jtm_pkg::FIN_W-1:0]  m2;
		logic                       last;
	} sched_entry_t;

	typedef struct packed {
		logic [1:0]                 preset;
		logic [jtm_pkg::KIND_W-1:0] kind;
		logic                       last;
		logic                       typed;
		logic [jtm_pkg::IDX_W-1:0]  e_idx;
		logic [jtm_pkg::KIND_W-1:0] e_kind;
		logic [jtm_pkg::FIN_W-1:0]  e_m1;
		logic [jtm_pkg::FIN_W-1:0]  e_m2;
	} dir_row_t;

	// directed jobs: lone job after reset, lone job at full scale, a full
	// store with two dropped jobs (the second carries last), back-group ties
	localparam dir_row_t DIRECTED [24] = '{
		'{CFG_KEEP,       2'd2, 1'b1, 1'b1, 4'd0, 2'd2, 13'd0,   13'd0},
		'{CFG_FULL_SCALE, 2'd3, 1'b1, 1'b1, 4'd0, 2'd3, 13'd255, 13'd510},
		'{CFG_MIXED,      2'd3, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd1, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd2, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd0, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd0, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd2, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd1, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd3, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd2, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd2, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd0, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd1, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd3, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd3, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd1, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd0, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd2, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd1, 1'b1, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_TIES,       2'd2, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd1, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd3, 1'b0, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0},
		'{CFG_KEEP,       2'd0, 1'b1, 1'b0, 4'd0, 2'd0, 13'd0,   13'd0}
	};

	logic                         clk;
	logic                         arst_n    = 1'b0;
	logic                         psel      = 1'b0;
	logic                         penable   = 1'b0;
	logic                         pwrite    = 1'b0;
	logic [jtm_pkg::PADDR_W-1:0]  paddr     = '0;
	logic [jtm_pkg::PDATA_W-1:0]  pwdata    = '0;
	logic [jtm_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	logic [jtm_pkg::KIND_W-1:0]   job_kind  = '0;
	logic                         load_last = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [jtm_pkg::IDX_W-1:0]    job_index;
	logic [jtm_pkg::KIND_W-1:0]   job_kind_out;
	logic [jtm_pkg::FIN_W-1:0]    m1_finish;
	logic [jtm_pkg::FIN_W-1:0]    m2_finish;
	logic                         sched_last;

	// scheduler model state
	logic [jtm_pkg::KIND_W-1:0]   loaded_kind [JOBS];
	int                           loaded_cnt = 0;
	jtm_pkg::time_tab_t           m1_time = '0;
	jtm_pkg::time_tab_t           m2_time = '0;
	sched_entry_t                 expected_sched [$];

	int                           idle_pct    = 38;
	int                           fail_cnt    = 0;
	int                           jobs_sent   = 0;
	int                           sets_sent   = 0;
	int                           sched_seen  = 0;
	int                           cfg_phases  = 0;
	sched_entry_t                 want;

	johnson_two_machine_scheduler_unit #(
		.JOBS(JOBS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.job_kind    (job_kind),
		.load_last   (load_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.job_index   (job_index),
		.job_kind_out(job_kind_out),
		.m1_finish   (m1_finish),
		.m2_finish   (m2_finish),
		.sched_last  (sched_last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("johnson_two_machine_scheduler_unit test failed");
		$finish;
	end

	// johnson order: front group (t1 <= t2) first by ascending t1,
	// back group by descending t2, equal keys keep load order
	function automatic bit runs_ahead(input int a, input int b);
		logic [jtm_pkg::KIND_W-1:0] ka;
		logic [jtm_pkg::KIND_W-1:0] kb;
		bit                         fa;
		bit                         fb;
		ka = loaded_kind[a];
		kb = loaded_kind[b];
		fa = m1_time[ka] <= m2_time[ka];
		fb = m1_time[kb] <= m2_time[kb];
		if (fa != fb)
			return fa;
		if (fa)
			return m1_time[ka] < m1_time[kb];
		return m2_time[ka] > m2_time[kb];
	endfunction

	// store one job; on last, sort the set and queue its schedule
	function automatic void plan_schedule(input logic [jtm_pkg::KIND_W-1:0] kind,
			input logic last, input bit record);
		int                         order [JOBS];
		int                         n;
		int                         j;
		int                         c1;
		int                         c2;
		logic [jtm_pkg::KIND_W-1:0] k;
		sched_entry_t               e;
		if (loaded_cnt < JOBS) begin
			loaded_kind[loaded_cnt] = kind;
			loaded_cnt++;
		end
		if (!last)
			return;
		n = loaded_cnt;
		for (int i = 0; i < n; i++) begin
			j = i;
			while (j > 0 && runs_ahead(i, order[j-1])) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		c1 = 0;
		c2 = 0;
		for (int i = 0; i < n; i++) begin
			k = loaded_kind[order[i]];
			c1 = c1 + int'(m1_time[k]);
			if (c1 > int'(jtm_pkg::FIN_MAX))
				c1 = int'(jtm_pkg::FIN_MAX);
			c2 = ((c1 > c2) ? c1 : c2) + int'(m2_time[k]);
			if (c2 > int'(jtm_pkg::FIN_MAX))
				c2 = int'(jtm_pkg::FIN_MAX);
			e.idx  = jtm_pkg::IDX_W'(order[i]);
			e.kind = k;
			e.m1   = jtm_pkg::FIN_W'(c1);
			e.m2   = jtm_pkg::FIN_W'(c2);
			e.last = (i == n - 1);
			if (record)
				expected_sched.push_back(e);
		end
		loaded_cnt = 0;
	endfunction

	function automatic void check_field(input string name, input int exp_val, input int got);
		if (exp_val != got) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got);
			fail_cnt++;
		end
	endfunction

	// one job transaction, held until accepted
	task automatic send_job(input logic [jtm_pkg::KIND_W-1:0] kind, input logic last);
		idle_pct = (jobs_sent >= 150 && jobs_sent < 220) ? 0 : 38;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		job_kind  <= kind;
		load_last <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		jobs_sent++;
		if (last)
			sets_sent++;
	endtask

	// apb write: setup and access phases, then idle
	task automatic write_reg(input logic [2:0] idx, input logic [jtm_pkg::TIME_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_times(input jtm_pkg::time_tab_t t1, input jtm_pkg::time_tab_t t2);
		for (int k = 0; k < jtm_pkg::KINDS; k++) begin
			write_reg(3'(jtm_pkg::REG_M1_KIND0 + k), t1[k]);
			write_reg(3'(jtm_pkg::REG_M2_KIND0 + k), t2[k]);
		end
		m1_time = t1;
		m2_time = t2;
		cfg_phases++;
	endtask

	// drain all schedules, then give the block time to go idle
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_sched.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// schedule checker and receiver back-pressure
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sched_seen++;
			if (expected_sched.size() == 0) begin
				$error("schedule transaction with none pending: index %0d", job_index);
				fail_cnt++;
			end else begin
				want = expected_sched.pop_front();
				check_field("job_index", want.idx, job_index);
				check_field("job_kind_out", want.kind, job_kind_out);
				check_field("m1_finish", want.m1, m1_finish);
				check_field("m2_finish", want.m2, m2_finish);
				check_field("sched_last", want.last, sched_last);
			end
		end
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	initial begin
		dir_row_t                   row;
		sched_entry_t               typed_e;
		jtm_pkg::time_tab_t         t1;
		jtm_pkg::time_tab_t         t2;
		logic [jtm_pkg::KIND_W-1:0] kind;
		int                         set_size;
		int                         pick;
		int                         mode;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (DIRECTED[r]) begin
			row = DIRECTED[r];
			if (row.preset != CFG_KEEP) begin
				settle();
				load_times(PRESET_M1[row.preset], PRESET_M2[row.preset]);
			end
			send_job(row.kind, row.last);
			plan_schedule(row.kind, row.last, !row.typed);
			if (row.typed) begin
				typed_e = '{row.e_idx, row.e_kind, row.e_m1, row.e_m2, 1'b1};
				expected_sched.push_back(typed_e);
			end
		end

		// random job sets, times changed now and then
		while (jobs_sent < ITEMS) begin
			if ($urandom_range(4) == 0) begin
				mode = $urandom_range(4);
				for (int k = 0; k < jtm_pkg::KINDS; k++) begin
					case (mode)
						0: begin
							t1[k] = '0;
							t2[k] = '0;
						end
						1: begin
							t1[k] = '1;
							t2[k] = '1;
						end
						2: begin
							t1[k] = jtm_pkg::TIME_W'($urandom);
							t2[k] = jtm_pkg::TIME_W'($urandom);
						end
						3: begin
							t1[k] = jtm_pkg::TIME_W'($urandom_range(3));
							t2[k] = jtm_pkg::TIME_W'($urandom_range(3));
						end
						default: begin
							t1[k] = jtm_pkg::TIME_W'($urandom);
							t2[k] = $urandom_range(1) ? t1[k] : jtm_pkg::TIME_W'($urandom);
						end
					endcase
				end
				settle();
				load_times(t1, t2);
			end
			pick = $urandom_range(99);
			if (pick < 70)
				set_size = $urandom_range(5, 1);
			else if (pick < 85)
				set_size = $urandom_range(15, 6);
			else if (pick < 93)
				set_size = JOBS;
			else
				set_size = $urandom_range(JOBS + 4, JOBS + 1);
			for (int i = 0; i < set_size; i++) begin
				kind = jtm_pkg::KIND_W'($urandom_range(3));
				send_job(kind, i == set_size - 1);
				plan_schedule(kind, i == set_size - 1, 1'b1);
			end
		end

		settle();
		$display("loaded %0d jobs in %0d sets, checked %0d schedule transactions",
			jobs_sent, sets_sent, sched_seen);
		$display("kind times reprogrammed %0d times between sets", cfg_phases);
		if (fail_cnt == 0)
			$display("johnson_two_machine_scheduler_unit test passed");
		else
			$display("johnson_two_machine_scheduler_unit test failed");
		$finish;
	end

endmodule

### files.f
rtl/jtm_pkg.sv
rtl/jtm_cfg_regs.sv
rtl/jtm_datapath.sv
rtl/jtm_ctrl.sv
rtl/johnson_two_machine_scheduler_unit.sv
dv/tb.sv
